### rtl/core/keeq_pkg.sv
// shared types and constants for the key edge event queue
`default_nettype none

package keeq_pkg;

  // sizing
  localparam int unsigned KEY_COUNT   = 256;
  localparam int unsigned QUEUE_DEPTH = 64;
  localparam int unsigned KEY_AW      = $clog2(KEY_COUNT);
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int unsigned COUNT_W     = $clog2(QUEUE_DEPTH + 1);

  // operation codes
  localparam logic [1:0] OP_SAMPLE = 2'd0;
  localparam logic [1:0] OP_POP    = 2'd1;
  localparam logic [1:0] OP_PEEK   = 2'd2;
  localparam logic [1:0] OP_CLEAR  = 2'd3;

  // event kinds
  localparam logic [1:0] KIND_PRESSED  = 2'd0;
  localparam logic [1:0] KIND_HELD     = 2'd1;
  localparam logic [1:0] KIND_RELEASED = 2'd2;

  // per-key flags as stored in the flag table
  typedef struct packed {
    logic released;
    logic held;
    logic pressed;
  } flags_t;

  // one queued event
  typedef struct packed {
    logic [7:0]  key;
    logic [1:0]  kind;
    logic [31:0] stamp;
  } entry_t;

  // request to the event queue
  typedef struct packed {
    logic push;
    logic pop;
    logic clear;
    logic rd_en;
  } fifo_cmd_t;

  // input item
  typedef struct packed {
    logic [1:0]  operation;
    logic [7:0]  key;
    logic        is_down;
    logic [31:0] stamp_ms;
  } in_item_t;

  // result item
  typedef struct packed {
    logic        event_valid;
    logic [7:0]  event_key;
    logic [1:0]  event_kind;
    logic [31:0] event_stamp;
    logic        now_pressed;
    logic        now_held;
    logic        now_released;
    logic [6:0]  queued;
  } out_item_t;

endpackage

`default_nettype wire

### rtl/core/keeq_flag_ram.sv
// per-key flag memory with a clearing sweep after reset
`default_nettype none

module keeq_flag_ram (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          rd_en_i,
  input  wire logic [keeq_pkg::KEY_AW-1:0]   rd_addr_i,
  input  wire logic                          wr_en_i,
  input  wire logic [keeq_pkg::KEY_AW-1:0]   wr_addr_i,
  input  wire keeq_pkg::flags_t              wr_flags_i,
  output keeq_pkg::flags_t                   rd_flags_o,
  output logic                               init_done_o
);
  import keeq_pkg::*;

  flags_t              mem [KEY_COUNT];
  flags_t              rd_q;
  logic                clr_busy_q, clr_busy_d;
  logic [KEY_AW-1:0]   clr_idx_q, clr_idx_d;
  logic                we;
  logic [KEY_AW-1:0]   wa;
  flags_t              wd;

  // sweep pointer walks every entry once after reset
  always_comb begin
    clr_busy_d = clr_busy_q;
    clr_idx_d  = clr_idx_q;
    if (clr_busy_q) begin
      clr_idx_d = clr_idx_q + 1'b1;
      if (clr_idx_q == KEY_AW'(KEY_COUNT - 1)) begin
        clr_busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_idx_q  <= '0;
    end else begin
      clr_busy_q <= clr_busy_d;
      clr_idx_q  <= clr_idx_d;
    end
  end

  // write port shared between sweep and updates
  assign we = clr_busy_q | wr_en_i;
  assign wa = clr_busy_q ? clr_idx_q : wr_addr_i;
  assign wd = clr_busy_q ? flags_t'('0) : wr_flags_i;

  // memory array, registered read
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (rd_en_i) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  assign rd_flags_o  = rd_q;
  assign init_done_o = ~clr_busy_q;

endmodule

`default_nettype wire

### rtl/core/keeq_event_fifo.sv
// ring buffer of events that drops its oldest entry when full
`default_nettype none

module keeq_event_fifo (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire keeq_pkg::fifo_cmd_t            cmd_i,
  input  wire keeq_pkg::entry_t               push_entry_i,
  output keeq_pkg::entry_t                    rd_entry_o,
  output logic [keeq_pkg::COUNT_W-1:0]        count_o,
  output logic [keeq_pkg::COUNT_W-1:0]        count_next_o
);
  import keeq_pkg::*;

  entry_t                mem [QUEUE_DEPTH];
  entry_t                rd_q;
  logic [QUEUE_AW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QUEUE_AW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [COUNT_W-1:0]    count_q, count_d;
  logic                  full;

  function automatic logic [QUEUE_AW-1:0] next_slot(input logic [QUEUE_AW-1:0] p);
    logic [QUEUE_AW-1:0] r;
    if (p == QUEUE_AW'(QUEUE_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

  assign full = (count_q == COUNT_W'(QUEUE_DEPTH));

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (cmd_i.clear) begin
      wr_ptr_d = '0;
      rd_ptr_d = '0;
      count_d  = '0;
    end else if (cmd_i.push) begin
      wr_ptr_d = next_slot(wr_ptr_q);
      if (full) begin
        rd_ptr_d = next_slot(rd_ptr_q);
      end else begin
        count_d = count_q + 1'b1;
      end
    end else if (cmd_i.pop && (count_q != '0)) begin
      rd_ptr_d = next_slot(rd_ptr_q);
      count_d  = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // event memory, registered read at the head
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      mem[wr_ptr_q] <= push_entry_i;
    end
    if (cmd_i.rd_en) begin
      rd_q <= mem[rd_ptr_q];
    end
  end

  assign rd_entry_o   = rd_q;
  assign count_o      = count_q;
  assign count_next_o = count_d;

endmodule

`default_nettype wire

### rtl/core/key_edge_event_queue.sv
// top level: key edge detector feeding an overwriting event queue
// flow: an accepted item and its flag read are registered, the exec state works it and loads
//   the result register; a sample that turns a key pressed also passes a push state (two events go into the queue)
// one item in flight: no new item is taken until the last result is loaded, and output stalls hold the
//   exec and push states; set by the read-modify-write of the flag memory and the single queue write port
// reset: the flag memory is swept to zero over all KEY_COUNT (256) entries, input stalled
`default_nettype none

module key_edge_event_queue (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire keeq_pkg::in_item_t  in_item_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output keeq_pkg::out_item_t      out_item_o
);
  import keeq_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_EXEC  = 2'd1;
  localparam logic [1:0] ST_PUSH2 = 2'd2;

  logic [1:0]          state_q, state_d;
  in_item_t            item_q;
  logic                accept;
  logic                init_done;
  logic                slot_free;
  logic                key_ok;
  logic                load;
  logic                flag_we;
  flags_t              prev_flags;
  flags_t              nflags;
  fifo_cmd_t           fifo_cmd;
  entry_t              push_entry;
  entry_t              head_entry;
  logic [COUNT_W-1:0]  count;
  logic [COUNT_W-1:0]  count_next;
  out_item_t           out_d;
  out_item_t           out_q;
  logic                out_valid_q, out_valid_d;

  assign in_stall_o = (state_q != ST_IDLE) | ~init_done;
  assign accept     = in_valid_i & ~in_stall_o;
  assign slot_free  = ~out_valid_q | ~out_stall_i;
  assign key_ok     = (item_q.key != 8'd0) && (32'(item_q.key) < KEY_COUNT);

  keeq_flag_ram u_flag_ram (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_en_i     (accept && (in_item_i.operation == OP_SAMPLE)),
    .rd_addr_i   (KEY_AW'(in_item_i.key)),
    .wr_en_i     (flag_we),
    .wr_addr_i   (KEY_AW'(item_q.key)),
    .wr_flags_i  (nflags),
    .rd_flags_o  (prev_flags),
    .init_done_o (init_done)
  );

  keeq_event_fifo u_event_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (fifo_cmd),
    .push_entry_i (push_entry),
    .rd_entry_o   (head_entry),
    .count_o      (count),
    .count_next_o (count_next)
  );

  // sequencer and result assembly
  always_comb begin
    state_d          = state_q;
    fifo_cmd         = '0;
    fifo_cmd.rd_en   = accept &&
                       ((in_item_i.operation == OP_POP) || (in_item_i.operation == OP_PEEK));
    push_entry.key   = item_q.key;
    push_entry.kind  = KIND_HELD;
    push_entry.stamp = item_q.stamp_ms;
    flag_we          = 1'b0;
    nflags           = '0;
    load             = 1'b0;
    out_d            = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (slot_free) begin
          unique case (item_q.operation) inside
            OP_SAMPLE: begin
              if (key_ok) begin
                flag_we = 1'b1;
                if (item_q.is_down) begin
                  nflags.held   = 1'b1;
                  fifo_cmd.push = 1'b1;
                  if (!prev_flags.held) begin
                    nflags.pressed  = 1'b1;
                    push_entry.kind = KIND_PRESSED;
                  end
                end else if (prev_flags.pressed || prev_flags.held) begin
                  nflags.released = 1'b1;
                  fifo_cmd.push   = 1'b1;
                  push_entry.kind = KIND_RELEASED;
                end
              end
              if (nflags.pressed) begin
                state_d = ST_PUSH2;
              end else begin
                load    = 1'b1;
                state_d = ST_IDLE;
              end
            end
            OP_POP, OP_PEEK: begin
              if (count != '0) begin
                out_d.event_valid = 1'b1;
                out_d.event_key   = head_entry.key;
                out_d.event_kind  = head_entry.kind;
                out_d.event_stamp = head_entry.stamp;
                fifo_cmd.pop      = (item_q.operation == OP_POP);
              end
              load    = 1'b1;
              state_d = ST_IDLE;
            end
            OP_CLEAR: begin
              fifo_cmd.clear = 1'b1;
              load           = 1'b1;
              state_d        = ST_IDLE;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
          out_d.now_pressed  = nflags.pressed;
          out_d.now_held     = nflags.held;
          out_d.now_released = nflags.released;
        end
      end
      ST_PUSH2: begin
        // second event of a new press
        if (slot_free) begin
          fifo_cmd.push      = 1'b1;
          out_d.now_pressed  = 1'b1;
          out_d.now_held     = 1'b1;
          load               = 1'b1;
          state_d            = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    out_d.queued = 7'(count_next);
  end

  // output register
  assign out_valid_d = load | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_item_i;
    end
    if (load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire

### rtl/core/keeq_checker.sv
// port-level checks for the key edge event queue, bound to the top level
`default_nettype none

module keeq_checker (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                out_valid_o,
  input  wire logic                out_stall_i,
  input  wire keeq_pkg::out_item_t out_item_o
);
  import keeq_pkg::*;

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_item_o))
    else $error("result changed while stalled");

  // a new press is always reported as held too, never as released
  a_press_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.now_pressed |-> out_item_o.now_held && !out_item_o.now_released)
    else $error("press reported without held");

  // a returned event never comes with key sample flags
  a_event_no_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.event_valid |->
      !out_item_o.now_pressed && !out_item_o.now_held && !out_item_o.now_released)
    else $error("event and sample flags in one result");

  // fill level stays within the queue depth
  a_queued_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_item_o.queued <= 7'(QUEUE_DEPTH))
    else $error("queue level beyond depth");

endmodule

bind key_edge_event_queue keeq_checker u_keeq_checker (.*);

`default_nettype wire

### sim/tb_key_edge_event_queue.sv
// testbench for the key edge event queue: random and directed items checked against a predictor
`default_nettype none

module tb_key_edge_event_queue;
  import keeq_pkg::*;

  // clock, reset and channel signals
  logic      clk_i     = 1'b0;
  logic      rst_ni    = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_item   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  // stimulus and expected results
  in_item_t  pending_items[$];
  out_item_t expected_results[$];
  int        sent_count     = 0;
  int        results_seen   = 0;
  int        mismatch_count = 0;

  // predictor state: per-key flags and the event ring
  flags_t flag_model [KEY_COUNT];
  entry_t event_ring [QUEUE_DEPTH];
  int     ring_wr   = 0;
  int     ring_rd   = 0;
  int     ring_fill = 0;

  key_edge_event_queue i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item)
  );

  // clock with period 2
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // push one event into the ring, dropping the oldest when full
  function automatic void push_event(logic [7:0] key, logic [1:0] kind, logic [31:0] stamp);
    if (ring_fill >= QUEUE_DEPTH) begin
      ring_rd   = (ring_rd + 1) % QUEUE_DEPTH;
      ring_fill = ring_fill - 1;
    end
    event_ring[ring_wr].key   = key;
    event_ring[ring_wr].kind  = kind;
    event_ring[ring_wr].stamp = stamp;
    ring_wr   = (ring_wr + 1) % QUEUE_DEPTH;
    ring_fill = ring_fill + 1;
  endfunction

  // apply one item to the predictor state and return its result
  function automatic out_item_t key_event_result(in_item_t it);
    out_item_t r;
    flags_t    prev;
    flags_t    nf;
    entry_t    head;
    r  = '0;
    nf = '0;
    case (it.operation)
      OP_SAMPLE: begin
        // key zero and keys past the table are ignored
        if (it.key != 8'd0 && int'(it.key) < int'(KEY_COUNT)) begin
          prev = flag_model[it.key];
          if (it.is_down) begin
            if (!prev.held) begin
              nf.pressed = 1'b1;
              push_event(it.key, KIND_PRESSED, it.stamp_ms);
            end
            nf.held = 1'b1;
            push_event(it.key, KIND_HELD, it.stamp_ms);
          end else if (prev.pressed || prev.held) begin
            nf.released = 1'b1;
            push_event(it.key, KIND_RELEASED, it.stamp_ms);
          end
          flag_model[it.key] = nf;
        end
      end
      OP_POP, OP_PEEK: begin
        if (ring_fill != 0) begin
          head          = event_ring[ring_rd];
          r.event_valid = 1'b1;
          r.event_key   = head.key;
          r.event_kind  = head.kind;
          r.event_stamp = head.stamp;
          if (it.operation == OP_POP) begin
            ring_rd   = (ring_rd + 1) % QUEUE_DEPTH;
            ring_fill = ring_fill - 1;
          end
        end
      end
      default: begin
        ring_wr   = 0;
        ring_rd   = 0;
        ring_fill = 0;
      end
    endcase
    r.now_pressed  = nf.pressed;
    r.now_held     = nf.held;
    r.now_released = nf.released;
    r.queued       = 7'(ring_fill);
    return r;
  endfunction

  // queue one item for the driver
  task automatic add_item(logic [1:0] op, logic [7:0] key, logic down, logic [31:0] stamp);
    in_item_t it;
    it.operation = op;
    it.key       = key;
    it.is_down   = down;
    it.stamp_ms  = stamp;
    pending_items.push_back(it);
  endtask

  // input driver: predicts each item as it is accepted
  always @(posedge clk_i) begin
    if (rst_ni && (!in_valid || !in_stall)) begin
      if (in_valid) begin
        expected_results.push_back(key_event_result(in_item));
      end
      if (pending_items.size() != 0 &&
          ((sent_count >= 400 && sent_count < 600) || $urandom_range(0, 99) >= 6)) begin
        in_item    <= pending_items.pop_front();
        in_valid   <= 1'b1;
        sent_count <= sent_count + 1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result monitor and random back-pressure
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni) begin
      if (out_valid && !out_stall) begin
        results_seen <= results_seen + 1;
        if (expected_results.size() == 0) begin
          if (mismatch_count < 10) begin
            $display("unexpected result: got %p", out_item);
          end
          mismatch_count <= mismatch_count + 1;
        end else begin
          want = expected_results.pop_front();
          if (out_item.event_valid  !== want.event_valid  ||
              out_item.event_key    !== want.event_key    ||
              out_item.event_kind   !== want.event_kind   ||
              out_item.event_stamp  !== want.event_stamp  ||
              out_item.now_pressed  !== want.now_pressed  ||
              out_item.now_held     !== want.now_held     ||
              out_item.now_released !== want.now_released ||
              out_item.queued       !== want.queued) begin
            if (mismatch_count < 10) begin
              $display("mismatch on result %0d: expected %p, got %p",
                       results_seen, want, out_item);
            end
            mismatch_count <= mismatch_count + 1;
          end
        end
      end
      out_stall <= !(results_seen >= 500 && results_seen < 700) &&
                   ($urandom_range(0, 99) < 6);
    end
  end

  // run limit
  initial begin
    #400000;
    $display("Some tests failed");
    $finish;
  end

  // stimulus and end of run
  initial begin
    int          mode;
    int          roll;
    int          sample_pct;
    logic [1:0]  op;
    logic [7:0]  key;
    for (int k = 0; k < KEY_COUNT; k++) begin
      flag_model[k] = '0;
    end

    // directed: empty queue, key zero, extremes, every operation
    add_item(OP_POP,    8'd0,   1'b0, 32'h0);
    add_item(OP_PEEK,   8'hff,  1'b1, 32'hffffffff);
    add_item(OP_SAMPLE, 8'd0,   1'b1, 32'h12345678);
    add_item(OP_SAMPLE, 8'd255, 1'b1, 32'hffffffff);
    add_item(OP_SAMPLE, 8'd255, 1'b1, 32'h0);
    add_item(OP_PEEK,   8'd0,   1'b0, 32'h0);
    add_item(OP_POP,    8'd0,   1'b0, 32'h0);
    add_item(OP_SAMPLE, 8'd255, 1'b0, 32'haaaaaaaa);
    add_item(OP_SAMPLE, 8'd255, 1'b0, 32'h55555555);
    add_item(OP_SAMPLE, 8'd1,   1'b0, 32'h1);
    add_item(OP_SAMPLE, 8'd1,   1'b1, 32'h55555555);
    add_item(OP_SAMPLE, 8'd128, 1'b1, 32'h80000000);
    add_item(OP_CLEAR,  8'd0,   1'b0, 32'h0);
    add_item(OP_POP,    8'd0,   1'b0, 32'h0);
    add_item(OP_SAMPLE, 8'd1,   1'b1, 32'h2);
    add_item(OP_SAMPLE, 8'd1,   1'b0, 32'h3);
    add_item(OP_SAMPLE, 8'd1,   1'b1, 32'h4);
    add_item(OP_POP,    8'd0,   1'b0, 32'h0);
    add_item(OP_POP,    8'd0,   1'b0, 32'h0);
    add_item(OP_PEEK,   8'd0,   1'b0, 32'h0);
    add_item(OP_POP,    8'd0,   1'b0, 32'h0);
    add_item(OP_POP,    8'd0,   1'b0, 32'h0);
    add_item(OP_CLEAR,  8'hff,  1'b1, 32'hffffffff);

    // random: chunks that fill, drain or mix, over a small key pool
    for (int c = 0; c < 20; c++) begin
      mode       = $urandom_range(0, 2);
      sample_pct = (mode == 0) ? 85 : (mode == 1) ? 25 : 55;
      for (int n = 0; n < 50; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < 2) begin
          op = OP_CLEAR;
        end else if (roll < 2 + sample_pct) begin
          op = OP_SAMPLE;
        end else if (roll < 10 + sample_pct) begin
          op = OP_PEEK;
        end else begin
          op = OP_POP;
        end
        key = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                                          : 8'($urandom_range(1, 6));
        add_item(op, key, 1'($urandom_range(0, 1)), $urandom());
      end
    end

    // hold reset from the start, then release it
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // wait for every item to be accepted and answered
    while (pending_items.size() != 0 || in_valid) @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

### key_edge_event_queue.f
rtl/core/keeq_pkg.sv
rtl/core/keeq_flag_ram.sv
rtl/core/keeq_event_fifo.sv
rtl/core/key_edge_event_queue.sv
rtl/core/keeq_checker.sv
sim/tb_key_edge_event_queue.sv
